// ===== rtl/lc_circuit_trapezoid_step_defines.svh =====
// Assertion macros used by the checker of the circuit step block.
`ifndef LC_CIRCUIT_TRAPEZOID_STEP_DEFINES_SVH
`define LC_CIRCUIT_TRAPEZOID_STEP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LCTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcts assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LCTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcts assertion failed");

`endif

// ===== rtl/lcts_pkg.sv =====
// Shared types, codes and the microprogram of the circuit step block.
package lcts_pkg;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_INIT,
		OP_PIV0,
		OP_PIV1,
		OP_PIV2,
		OP_COMMIT,
		OP_LOADST,
		OP_END
	} op_t;

	typedef enum logic [4:0] {
		R_M00, R_M01, R_M02,
		R_M10, R_M11, R_M12,
		R_M20, R_M21, R_M22,
		R_V0, R_V1, R_V2,
		R_T, R_D, R_F, R_L,
		R_WCOMP, R_BCOMP, R_CAP, R_PAR, R_LOAD, R_SER, R_BIAS,
		R_WCUR, R_BCUR, R_CVOLT, R_RPREV, R_RNEW
	} reg_t;

	typedef struct packed {
		op_t  op;
		reg_t dst;
		reg_t sa;
		reg_t sb;
	} uop_t;

	localparam int UPC_W = 6;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UC_START = upc_t'(0);
	localparam upc_t UC_EMIT  = upc_t'(59);
	localparam upc_t UC_LOAD  = upc_t'(62);

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WCOMP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BCOMP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SER   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = 3'd6;

	typedef struct packed {
		logic issue;
		uop_t uop;
		logic capture;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic unit_done;
		logic pivot_zero;
	} stat_t;

	function automatic uop_t mk(op_t o, reg_t d, reg_t a, reg_t b);
		uop_t u;
		u.op  = o;
		u.dst = d;
		u.sa  = a;
		u.sb  = b;
		return u;
	endfunction

	// Build system, forward elimination, back substitution, then result; a load only takes the state and forms the result.
	function automatic uop_t ucode(upc_t pc);
		uop_t u;
		case (pc)
			upc_t'(0):  u = mk(OP_INIT, R_T, R_T, R_T);
			upc_t'(1):  u = mk(OP_ADD, R_M00, R_WCOMP, R_LOAD);
			upc_t'(2):  u = mk(OP_ADD, R_M00, R_M00, R_RNEW);
			upc_t'(3):  u = mk(OP_ADD, R_M00, R_M00, R_SER);
			upc_t'(4):  u = mk(OP_ADD, R_M11, R_BCOMP, R_LOAD);
			upc_t'(5):  u = mk(OP_ADD, R_M11, R_M11, R_PAR);
			upc_t'(6):  u = mk(OP_MUL, R_T, R_LOAD, R_BIAS);
			upc_t'(7):  u = mk(OP_ADD, R_D, R_T, R_T);
			upc_t'(8):  u = mk(OP_ADD, R_D, R_CVOLT, R_D);
			upc_t'(9):  u = mk(OP_SUB, R_T, R_WCOMP, R_LOAD);
			upc_t'(10): u = mk(OP_SUB, R_T, R_T, R_RPREV);
			upc_t'(11): u = mk(OP_SUB, R_T, R_T, R_SER);
			upc_t'(12): u = mk(OP_MUL, R_T, R_T, R_WCUR);
			upc_t'(13): u = mk(OP_ADD, R_V0, R_D, R_T);
			upc_t'(14): u = mk(OP_MUL, R_T, R_LOAD, R_BCUR);
			upc_t'(15): u = mk(OP_SUB, R_V0, R_V0, R_T);
			upc_t'(16): u = mk(OP_SUB, R_T, R_BCOMP, R_LOAD);
			upc_t'(17): u = mk(OP_SUB, R_T, R_T, R_PAR);
			upc_t'(18): u = mk(OP_MUL, R_T, R_T, R_BCUR);
			upc_t'(19): u = mk(OP_ADD, R_V1, R_D, R_T);
			upc_t'(20): u = mk(OP_MUL, R_T, R_LOAD, R_WCUR);
			upc_t'(21): u = mk(OP_SUB, R_V1, R_V1, R_T);
			upc_t'(22): u = mk(OP_ADD, R_T, R_BIAS, R_BIAS);
			upc_t'(23): u = mk(OP_SUB, R_T, R_T, R_WCUR);
			upc_t'(24): u = mk(OP_SUB, R_T, R_T, R_BCUR);
			upc_t'(25): u = mk(OP_MUL, R_T, R_CAP, R_T);
			upc_t'(26): u = mk(OP_ADD, R_V2, R_CVOLT, R_T);
			upc_t'(27): u = mk(OP_PIV0, R_T, R_T, R_T);
			upc_t'(28): u = mk(OP_DIV, R_F, R_M10, R_M00);
			upc_t'(29): u = mk(OP_MUL, R_T, R_F, R_M01);
			upc_t'(30): u = mk(OP_SUB, R_M11, R_M11, R_T);
			upc_t'(31): u = mk(OP_MUL, R_T, R_F, R_M02);
			upc_t'(32): u = mk(OP_SUB, R_M12, R_M12, R_T);
			upc_t'(33): u = mk(OP_MUL, R_T, R_F, R_V0);
			upc_t'(34): u = mk(OP_SUB, R_V1, R_V1, R_T);
			upc_t'(35): u = mk(OP_DIV, R_F, R_M20, R_M00);
			upc_t'(36): u = mk(OP_MUL, R_T, R_F, R_M01);
			upc_t'(37): u = mk(OP_SUB, R_M21, R_M21, R_T);
			upc_t'(38): u = mk(OP_MUL, R_T, R_F, R_M02);
			upc_t'(39): u = mk(OP_SUB, R_M22, R_M22, R_T);
			upc_t'(40): u = mk(OP_MUL, R_T, R_F, R_V0);
			upc_t'(41): u = mk(OP_SUB, R_V2, R_V2, R_T);
			upc_t'(42): u = mk(OP_PIV1, R_T, R_T, R_T);
			upc_t'(43): u = mk(OP_DIV, R_F, R_M21, R_M11);
			upc_t'(44): u = mk(OP_MUL, R_T, R_F, R_M12);
			upc_t'(45): u = mk(OP_SUB, R_M22, R_M22, R_T);
			upc_t'(46): u = mk(OP_MUL, R_T, R_F, R_V1);
			upc_t'(47): u = mk(OP_SUB, R_V2, R_V2, R_T);
			upc_t'(48): u = mk(OP_PIV2, R_T, R_T, R_T);
			upc_t'(49): u = mk(OP_DIV, R_V2, R_V2, R_M22);
			upc_t'(50): u = mk(OP_MUL, R_T, R_M12, R_V2);
			upc_t'(51): u = mk(OP_SUB, R_V1, R_V1, R_T);
			upc_t'(52): u = mk(OP_DIV, R_V1, R_V1, R_M11);
			upc_t'(53): u = mk(OP_MUL, R_T, R_M01, R_V1);
			upc_t'(54): u = mk(OP_SUB, R_V0, R_V0, R_T);
			upc_t'(55): u = mk(OP_MUL, R_T, R_M02, R_V2);
			upc_t'(56): u = mk(OP_SUB, R_V0, R_V0, R_T);
			upc_t'(57): u = mk(OP_DIV, R_V0, R_V0, R_M00);
			upc_t'(58): u = mk(OP_COMMIT, R_T, R_T, R_T);
			upc_t'(59): u = mk(OP_SUB, R_T, R_BIAS, R_WCUR);
			upc_t'(60): u = mk(OP_SUB, R_L, R_T, R_BCUR);
			upc_t'(62): u = mk(OP_LOADST, R_T, R_T, R_T);
			default:    u = mk(OP_END, R_T, R_T, R_T);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/lc_circuit_trapezoid_step.sv =====
// Top level of the trapezoidal circuit step: one 3x3 solve per step request.
//
// Usage:
// - Configuration: write companion terms, resistances and bias through
//   cfg_we / cfg_idx / cfg_data while the block is idle; one write per cycle.
// - Input stream (s_*): one request per transaction. s_tuser selects load
//   (0) or advance one time step (1). A load takes the initial state and
//   forms its result from it without a solve.
// - A step builds the system and runs Gaussian elimination with partial
//   pivoting from a 62-entry microprogram, one micro-op per cycle while no
//   unit is busy; the sequencer waits for each of the 17 multiplies on the
//   shared multiplier and 6 divides on the shared divider to finish.
//   A zero pivot column ends the solve early.
// - One request is in work at a time; the next is accepted as soon as the
//   result sits in the output register.
// - Output stream (m_*): one result per request; m_tuser flags a singular
//   system, whose result shows the unchanged state.
// - Stall: a held result stays in the output register; a finished solve
//   waits until that register frees before new input is taken.
// - Reset (arst_n low): clears configuration, circuit state and valid flags.
module lc_circuit_trapezoid_step #(
	parameter int DATA_WIDTH = 48,
	parameter int FRAC_BITS  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lcts_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_WIDTH-1:0]          cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// wire_res_new, wire_cur_init, branch_cur_init, cap_volt_init, zero pad
	input  logic [((4*DATA_WIDTH-1+7)/8)*8-1:0] s_tdata,
	// req_type
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// wire_cur, branch_cur, cap_volt, load_cur
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// singular
	output logic [0:0]                     m_tuser
);

	localparam int W    = DATA_WIDTH;
	localparam int OTDW = ((4*W+7)/8)*8;

	lcts_pkg::cmd_t  cmd;
	lcts_pkg::stat_t stat;
	logic [W-1:0]    res_wcur, res_bcur, res_cvolt, res_lcur;
	logic            res_sing;

	lcts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser[0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Input fields unpack straight from the stream word; padding is ignored.
	lcts_dpath #(.W(W), .F(FRAC_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_rnew   (s_tdata[W-2:0]),
		.in_wcur   (s_tdata[2*W-2:W-1]),
		.in_bcur   (s_tdata[3*W-2:2*W-1]),
		.in_cvolt  (s_tdata[4*W-2:3*W-1]),
		.cmd       (cmd),
		.stat      (stat),
		.res_wcur  (res_wcur),
		.res_bcur  (res_bcur),
		.res_cvolt (res_cvolt),
		.res_lcur  (res_lcur),
		.res_sing  (res_sing)
	);

	assign m_tdata = OTDW'({res_lcur, res_cvolt, res_bcur, res_wcur});
	assign m_tuser = res_sing;

endmodule

// ===== rtl/lcts_mul.sv =====
// Sequential saturating fixed-point multiplier, four multiplier bits a cycle.
module lcts_mul #(
	parameter int W = 48,
	parameter int F = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] res
);

	localparam int MD   = 4;
	localparam int NDIG = (W + MD - 1) / MD;
	localparam int MBW  = NDIG * MD;
	localparam int CW   = $clog2(NDIG + 1);
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]     ma_q;
	logic [MBW-1:0]   mb_q;
	logic [2*W-1:0]   acc_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [W+MD-1:0]  pp;
	logic [2*W-1:0]   shp;
	logic [2*W-1:0]   lim;
	logic [W-1:0]     lo;
	logic [W-1:0]     mag_a;
	logic [W-1:0]     mag_b;

	assign mag_a = a[W-1] ? W'(0) - a : a;
	assign mag_b = b[W-1] ? W'(0) - b : b;
	assign pp    = (W+MD)'(ma_q) * (W+MD)'(mb_q[MBW-1 -: MD]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NDIG);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag_a;
			mb_q  <= MBW'(mag_b);
			acc_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			acc_q <= (acc_q << MD) + (2*W)'(pp);
			mb_q  <= mb_q << MD;
		end
	end

	// Drop the fraction, clamp the magnitude, then apply the sign.
	always_comb begin
		shp = acc_q >> F;
		lim = neg_q ? (2*W)'(VMIN) : (2*W)'(VMAX);
		lo  = (shp > lim) ? lim[W-1:0] : shp[W-1:0];
		res = neg_q ? W'(0) - lo : lo;
	end

	assign done = done_q;

endmodule

// ===== rtl/lcts_div.sv =====
// Sequential saturating fixed-point divider, restoring, one quotient bit a cycle.
module lcts_div #(
	parameter int W = 48,
	parameter int F = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] res
);

	localparam int NW = W + F;
	localparam int CW = $clog2(NW + 1);
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [W:0]    r_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    r2;
	logic          qbit;
	logic [W:0]    rn;
	logic [NW-1:0] lim;
	logic [W-1:0]  lo;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;

	assign mag_a = a[W-1] ? W'(0) - a : a;
	assign mag_b = b[W-1] ? W'(0) - b : b;

	always_comb begin
		r2   = {r_q[W-1:0], n_q[NW-1]};
		qbit = (r2 >= {1'b0, d_q});
		rn   = qbit ? r2 - {1'b0, d_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= NW'(mag_a) << F;
			d_q   <= mag_b;
			q_q   <= '0;
			r_q   <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			n_q <= n_q << 1;
			q_q <= {q_q[NW-2:0], qbit};
			r_q <= rn;
		end
	end

	always_comb begin
		lim = neg_q ? NW'(VMIN) : NW'(VMAX);
		lo  = (q_q > lim) ? lim[W-1:0] : q_q[W-1:0];
		res = neg_q ? W'(0) - lo : lo;
	end

	assign done = done_q;

endmodule

// ===== rtl/lcts_dpath.sv =====
// Datapath: configuration, circuit state, solve registers, arithmetic units.
module lcts_dpath #(
	parameter int W = 48,
	parameter int F = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lcts_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [W-1:0]                   cfg_data,
	input  logic [W-2:0]                   in_rnew,
	input  logic [W-1:0]                   in_wcur,
	input  logic [W-1:0]                   in_bcur,
	input  logic [W-1:0]                   in_cvolt,
	input  lcts_pkg::cmd_t                 cmd,
	output lcts_pkg::stat_t                stat,
	output logic [W-1:0]                   res_wcur,
	output logic [W-1:0]                   res_bcur,
	output logic [W-1:0]                   res_cvolt,
	output logic [W-1:0]                   res_lcur,
	output logic                           res_sing
);

	localparam logic [W-1:0] VMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE    = (F >= W - 1) ? VMAX : (W'(1) << F);
	localparam logic [W-1:0] NEGONE = W'(0) - ONE;

	function automatic logic [W-1:0] sat_add(logic [W-1:0] x, logic [W-1:0] y);
		logic [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1]) begin
			return s[W] ? VMIN : VMAX;
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat_neg(logic [W-1:0] x);
		return (x == VMIN) ? VMAX : W'(0) - x;
	endfunction

	function automatic logic [W-1:0] mag(logic [W-1:0] x);
		return x[W-1] ? W'(0) - x : x;
	endfunction

	logic [W-1:0] wcomp_q, bcomp_q, cap_q, bias_q;
	logic [W-2:0] par_q, load_q, ser_q;
	logic [W-1:0] wcur_q, bcur_q, cvolt_q;
	logic [W-2:0] rprev_q, rnew_q;
	logic [W-1:0] iwcur_q, ibcur_q, icvolt_q;
	logic [W-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
	logic [W-1:0] v0_q, v1_q, v2_q, t_q, d_q, f_q, l_q;
	logic         sing_q;

	lcts_pkg::op_t op;
	logic [W-1:0]  opa, opb, alu_res, wdata, mul_res, div_res;
	logic          mul_done, div_done, wr_en;
	logic [1:0]    piv_row;
	logic          piv_zero;
	logic [W-1:0]  best;

	assign op = cmd.uop.op;

	always_comb begin
		case (cmd.uop.sa)
			lcts_pkg::R_M00:   opa = m00_q;
			lcts_pkg::R_M01:   opa = m01_q;
			lcts_pkg::R_M02:   opa = m02_q;
			lcts_pkg::R_M10:   opa = m10_q;
			lcts_pkg::R_M11:   opa = m11_q;
			lcts_pkg::R_M12:   opa = m12_q;
			lcts_pkg::R_M20:   opa = m20_q;
			lcts_pkg::R_M21:   opa = m21_q;
			lcts_pkg::R_M22:   opa = m22_q;
			lcts_pkg::R_V0:    opa = v0_q;
			lcts_pkg::R_V1:    opa = v1_q;
			lcts_pkg::R_V2:    opa = v2_q;
			lcts_pkg::R_T:     opa = t_q;
			lcts_pkg::R_D:     opa = d_q;
			lcts_pkg::R_F:     opa = f_q;
			lcts_pkg::R_L:     opa = l_q;
			lcts_pkg::R_WCOMP: opa = wcomp_q;
			lcts_pkg::R_BCOMP: opa = bcomp_q;
			lcts_pkg::R_CAP:   opa = cap_q;
			lcts_pkg::R_PAR:   opa = {1'b0, par_q};
			lcts_pkg::R_LOAD:  opa = {1'b0, load_q};
			lcts_pkg::R_SER:   opa = {1'b0, ser_q};
			lcts_pkg::R_BIAS:  opa = bias_q;
			lcts_pkg::R_WCUR:  opa = wcur_q;
			lcts_pkg::R_BCUR:  opa = bcur_q;
			lcts_pkg::R_CVOLT: opa = cvolt_q;
			lcts_pkg::R_RPREV: opa = {1'b0, rprev_q};
			lcts_pkg::R_RNEW:  opa = {1'b0, rnew_q};
			default:           opa = '0;
		endcase
	end

	always_comb begin
		case (cmd.uop.sb)
			lcts_pkg::R_M00:   opb = m00_q;
			lcts_pkg::R_M01:   opb = m01_q;
			lcts_pkg::R_M02:   opb = m02_q;
			lcts_pkg::R_M10:   opb = m10_q;
			lcts_pkg::R_M11:   opb = m11_q;
			lcts_pkg::R_M12:   opb = m12_q;
			lcts_pkg::R_M20:   opb = m20_q;
			lcts_pkg::R_M21:   opb = m21_q;
			lcts_pkg::R_M22:   opb = m22_q;
			lcts_pkg::R_V0:    opb = v0_q;
			lcts_pkg::R_V1:    opb = v1_q;
			lcts_pkg::R_V2:    opb = v2_q;
			lcts_pkg::R_T:     opb = t_q;
			lcts_pkg::R_D:     opb = d_q;
			lcts_pkg::R_F:     opb = f_q;
			lcts_pkg::R_L:     opb = l_q;
			lcts_pkg::R_WCOMP: opb = wcomp_q;
			lcts_pkg::R_BCOMP: opb = bcomp_q;
			lcts_pkg::R_CAP:   opb = cap_q;
			lcts_pkg::R_PAR:   opb = {1'b0, par_q};
			lcts_pkg::R_LOAD:  opb = {1'b0, load_q};
			lcts_pkg::R_SER:   opb = {1'b0, ser_q};
			lcts_pkg::R_BIAS:  opb = bias_q;
			lcts_pkg::R_WCUR:  opb = wcur_q;
			lcts_pkg::R_BCUR:  opb = bcur_q;
			lcts_pkg::R_CVOLT: opb = cvolt_q;
			lcts_pkg::R_RPREV: opb = {1'b0, rprev_q};
			lcts_pkg::R_RNEW:  opb = {1'b0, rnew_q};
			default:           opb = '0;
		endcase
	end

	lcts_mul #(.W(W), .F(F)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.issue && (op == lcts_pkg::OP_MUL)),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.res    (mul_res)
	);

	lcts_div #(.W(W), .F(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.issue && (op == lcts_pkg::OP_DIV)),
		.a      (opa),
		.b      (opb),
		.done   (div_done),
		.res    (div_res)
	);

	// Subtraction adds the saturated negation, so a minimum operand clamps first.
	assign alu_res = (op == lcts_pkg::OP_SUB) ? sat_add(opa, sat_neg(opb)) : sat_add(opa, opb);
	assign wdata   = mul_done ? mul_res : (div_done ? div_res : alu_res);
	assign wr_en   = (cmd.issue && ((op == lcts_pkg::OP_ADD) || (op == lcts_pkg::OP_SUB)))
			|| mul_done || div_done;

	// Pivot search: largest magnitude in the column, lowest row on a tie.
	always_comb begin
		piv_row  = 2'd0;
		piv_zero = 1'b0;
		best     = '0;
		case (op)
			lcts_pkg::OP_PIV0: begin
				best = mag(m00_q);
				if (mag(m10_q) > best) begin
					piv_row = 2'd1;
					best    = mag(m10_q);
				end
				if (mag(m20_q) > best) begin
					piv_row = 2'd2;
					best    = mag(m20_q);
				end
				piv_zero = (best == '0);
			end
			lcts_pkg::OP_PIV1: begin
				piv_row = 2'd1;
				best    = mag(m11_q);
				if (mag(m21_q) > best) begin
					piv_row = 2'd2;
					best    = mag(m21_q);
				end
				piv_zero = (best == '0);
			end
			lcts_pkg::OP_PIV2: begin
				piv_row  = 2'd2;
				piv_zero = (m22_q == '0);
			end
			default: begin
				piv_row  = 2'd0;
				piv_zero = 1'b0;
			end
		endcase
	end

	assign stat.unit_done  = mul_done || div_done;
	assign stat.pivot_zero = piv_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcomp_q <= '0;
			bcomp_q <= '0;
			cap_q   <= '0;
			par_q   <= '0;
			load_q  <= '0;
			ser_q   <= '0;
			bias_q  <= '0;
			wcur_q  <= '0;
			bcur_q  <= '0;
			cvolt_q <= '0;
			rprev_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					lcts_pkg::CFG_WCOMP: wcomp_q <= cfg_data;
					lcts_pkg::CFG_BCOMP: bcomp_q <= cfg_data;
					lcts_pkg::CFG_CAP:   cap_q   <= cfg_data;
					lcts_pkg::CFG_PAR:   par_q   <= cfg_data[W-2:0];
					lcts_pkg::CFG_LOAD:  load_q  <= cfg_data[W-2:0];
					lcts_pkg::CFG_SER:   ser_q   <= cfg_data[W-2:0];
					lcts_pkg::CFG_BIAS:  bias_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.issue && (op == lcts_pkg::OP_LOADST)) begin
				wcur_q  <= iwcur_q;
				bcur_q  <= ibcur_q;
				cvolt_q <= icvolt_q;
				rprev_q <= rnew_q;
			end
			if (cmd.issue && (op == lcts_pkg::OP_COMMIT)) begin
				wcur_q  <= v0_q;
				bcur_q  <= v1_q;
				cvolt_q <= v2_q;
				rprev_q <= rnew_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rnew_q   <= in_rnew;
			iwcur_q  <= in_wcur;
			ibcur_q  <= in_bcur;
			icvolt_q <= in_cvolt;
			sing_q   <= 1'b0;
		end
		if (wr_en) begin
			case (cmd.uop.dst)
				lcts_pkg::R_M00: m00_q <= wdata;
				lcts_pkg::R_M01: m01_q <= wdata;
				lcts_pkg::R_M02: m02_q <= wdata;
				lcts_pkg::R_M10: m10_q <= wdata;
				lcts_pkg::R_M11: m11_q <= wdata;
				lcts_pkg::R_M12: m12_q <= wdata;
				lcts_pkg::R_M20: m20_q <= wdata;
				lcts_pkg::R_M21: m21_q <= wdata;
				lcts_pkg::R_M22: m22_q <= wdata;
				lcts_pkg::R_V0:  v0_q  <= wdata;
				lcts_pkg::R_V1:  v1_q  <= wdata;
				lcts_pkg::R_V2:  v2_q  <= wdata;
				lcts_pkg::R_T:   t_q   <= wdata;
				lcts_pkg::R_D:   d_q   <= wdata;
				lcts_pkg::R_F:   f_q   <= wdata;
				lcts_pkg::R_L:   l_q   <= wdata;
				default: ;
			endcase
		end
		// Fixed matrix entries, loaded together by the init micro-op.
		if (cmd.issue && (op == lcts_pkg::OP_INIT)) begin
			m01_q <= {1'b0, load_q};
			m02_q <= NEGONE;
			m10_q <= {1'b0, load_q};
			m12_q <= NEGONE;
			m20_q <= cap_q;
			m21_q <= cap_q;
			m22_q <= ONE;
		end
		if (cmd.issue && piv_zero) begin
			sing_q <= 1'b1;
		end
		// Row exchange after the pivot search.
		if (cmd.issue && (op == lcts_pkg::OP_PIV0) && (piv_row == 2'd1)) begin
			m00_q <= m10_q; m10_q <= m00_q;
			m01_q <= m11_q; m11_q <= m01_q;
			m02_q <= m12_q; m12_q <= m02_q;
			v0_q  <= v1_q;  v1_q  <= v0_q;
		end
		if (cmd.issue && (op == lcts_pkg::OP_PIV0) && (piv_row == 2'd2)) begin
			m00_q <= m20_q; m20_q <= m00_q;
			m01_q <= m21_q; m21_q <= m01_q;
			m02_q <= m22_q; m22_q <= m02_q;
			v0_q  <= v2_q;  v2_q  <= v0_q;
		end
		if (cmd.issue && (op == lcts_pkg::OP_PIV1) && (piv_row == 2'd2)) begin
			m10_q <= m20_q; m20_q <= m10_q;
			m11_q <= m21_q; m21_q <= m11_q;
			m12_q <= m22_q; m22_q <= m12_q;
			v1_q  <= v2_q;  v2_q  <= v1_q;
		end
		if (cmd.out_load) begin
			res_wcur  <= wcur_q;
			res_bcur  <= bcur_q;
			res_cvolt <= cvolt_q;
			res_lcur  <= l_q;
			res_sing  <= sing_q;
		end
	end

endmodule

// ===== rtl/lcts_ctrl.sv =====
// Controller: input handshake, microprogram sequencer, output valid.
module lcts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            req_type,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  lcts_pkg::stat_t stat,
	output lcts_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	state_t          state_q;
	lcts_pkg::upc_t  pc_q;
	logic            mvalid_q;
	lcts_pkg::uop_t  uop;

	assign uop          = lcts_pkg::ucode(pc_q);
	assign cmd.uop      = uop;
	assign cmd.issue    = (state_q == S_ISSUE);
	assign cmd.capture  = (state_q == S_IDLE) && s_tvalid;
	assign cmd.out_load = (state_q == S_HOLD) && (!mvalid_q || m_tready);
	assign s_tready     = (state_q == S_IDLE);
	assign m_tvalid     = mvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pc_q     <= lcts_pkg::UC_START;
			mvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pc_q    <= req_type ? lcts_pkg::UC_START : lcts_pkg::UC_LOAD;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					case (uop.op) inside
						lcts_pkg::OP_END: state_q <= S_HOLD;
						lcts_pkg::OP_MUL, lcts_pkg::OP_DIV: state_q <= S_WAIT;
						lcts_pkg::OP_PIV0, lcts_pkg::OP_PIV1, lcts_pkg::OP_PIV2: begin
							// Abandon the solve on a zero pivot column.
							pc_q <= stat.pivot_zero ? lcts_pkg::UC_EMIT
									: pc_q + lcts_pkg::upc_t'(1);
						end
						lcts_pkg::OP_LOADST: pc_q <= lcts_pkg::UC_EMIT;
						default: pc_q <= pc_q + lcts_pkg::upc_t'(1);
					endcase
				end
				S_WAIT: begin
					if (stat.unit_done) begin
						pc_q    <= pc_q + lcts_pkg::upc_t'(1);
						state_q <= S_ISSUE;
					end
				end
				S_HOLD: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/lcts_checker.sv =====
// Port-level checker for the circuit step block, with its bind.
`include "lc_circuit_trapezoid_step_defines.svh"

module lcts_checker #(
	parameter int DATA_WIDTH = 48
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((4*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
	input logic [0:0]                           m_tuser
);

	// A stalled result holds its payload.
	`LCTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A request is worked on alone: no new transaction right after one is taken.
	`LCTS_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)

	// A new result appears only at the end of a request's work, never from the idle state.
	`LCTS_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready))

endmodule

bind lc_circuit_trapezoid_step lcts_checker #(.DATA_WIDTH(DATA_WIDTH)) u_lcts_checker (.*);
